>>> src/tcprx_pkg.sv
// shared types and constants of the tcp connection receive state machine
// no dependencies

package tcprx_pkg;

    // tcp flag bits
    localparam logic [7:0] TCP_FIN = 8'h01;
    localparam logic [7:0] TCP_SYN = 8'h02;
    localparam logic [7:0] TCP_PSH = 8'h08;
    localparam logic [7:0] TCP_ACK = 8'h10;

    localparam logic [7:0] FLAGS_PSH_ACK = TCP_PSH | TCP_ACK;
    localparam logic [7:0] FLAGS_FIN_ACK = TCP_FIN | TCP_ACK;
    localparam logic [7:0] FLAGS_SYN_ACK = TCP_SYN | TCP_ACK;

    // stream word widths
    localparam int unsigned S_DATA_W = 128;
    localparam int unsigned M_DATA_W = 96;

    typedef enum logic [0:0] {
        CMD_SEGMENT = 1'b0,
        CMD_FORCE   = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_SYN_RECV    = 4'd2,
        ST_SYN_SENT    = 4'd3,
        ST_ESTABLISHED = 4'd4,
        ST_CLOSE_WAIT  = 4'd5,
        ST_LAST_ACK    = 4'd6,
        ST_FIN_WAIT_1  = 4'd7,
        ST_FIN_WAIT_2  = 4'd8,
        ST_CLOSING     = 4'd9,
        ST_TIME_WAIT   = 4'd10
    } conn_state_t;

    typedef enum logic [2:0] {
        REPLY_NONE   = 3'd0,
        REPLY_ACK    = 3'd1,
        REPLY_SYNACK = 3'd2,
        REPLY_FINACK = 3'd3,
        REPLY_RST    = 3'd4
    } reply_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  seg_flags;
        logic [31:0] seq_end;
        logic [31:0] ack_num;
        logic [15:0] payload_len;
        logic [31:0] send_next;
        logic [3:0]  forced_state;
    } seg_t;

    typedef struct packed {
        logic [3:0]  new_state;
        reply_t      reply_kind;
        logic [1:0]  reply_count;
        logic        spawn_child;
        logic        accept_ready;
        logic        wake_connect;
        logic        start_timewait;
        logic        deliver_valid;
        logic [15:0] deliver_len;
        logic [31:0] unacked_out;
        logic [31:0] rcv_next_out;
    } result_t;

endpackage

>>> src/tcprx_decode.sv
// combinational segment decode: next connection state, reply and event flags
// depends on tcprx_pkg

module tcprx_decode (
    input  tcprx_pkg::seg_t    seg,
    input  logic [3:0]         state_cur,
    input  logic [31:0]        unacked_cur,
    input  logic [31:0]        rcv_next_cur,
    output tcprx_pkg::result_t res
);

    logic       is_seg;
    logic       f_fin;
    logic       f_syn;
    logic       f_ack;
    logic [3:0] state_next;

    assign is_seg = (seg.cmd == tcprx_pkg::CMD_SEGMENT);
    assign f_fin  = (seg.seg_flags & tcprx_pkg::TCP_FIN) != 8'd0;
    assign f_syn  = (seg.seg_flags & tcprx_pkg::TCP_SYN) != 8'd0;
    assign f_ack  = (seg.seg_flags & tcprx_pkg::TCP_ACK) != 8'd0;

    // next state
    always_comb begin
        state_next = state_cur;
        if (!is_seg) begin
            state_next = seg.forced_state;
        end else begin
            case (state_cur)
                tcprx_pkg::ST_SYN_SENT: begin
                    if (f_syn || f_ack) state_next = tcprx_pkg::ST_ESTABLISHED;
                end
                tcprx_pkg::ST_SYN_RECV: begin
                    if (seg.seg_flags == tcprx_pkg::TCP_ACK && seg.ack_num == seg.send_next)
                        state_next = tcprx_pkg::ST_ESTABLISHED;
                end
                tcprx_pkg::ST_ESTABLISHED: begin
                    if (seg.seg_flags == tcprx_pkg::FLAGS_FIN_ACK)
                        state_next = tcprx_pkg::ST_LAST_ACK;
                    else if (seg.seg_flags == tcprx_pkg::TCP_FIN)
                        state_next = tcprx_pkg::ST_CLOSE_WAIT;
                end
                tcprx_pkg::ST_FIN_WAIT_1: begin
                    if (f_fin)      state_next = tcprx_pkg::ST_TIME_WAIT;
                    else if (f_ack) state_next = tcprx_pkg::ST_FIN_WAIT_2;
                end
                tcprx_pkg::ST_FIN_WAIT_2: begin
                    if (f_fin || f_ack) state_next = tcprx_pkg::ST_TIME_WAIT;
                end
                tcprx_pkg::ST_CLOSE_WAIT: begin
                    if (f_fin || f_ack) state_next = tcprx_pkg::ST_LAST_ACK;
                end
                tcprx_pkg::ST_LAST_ACK: begin
                    if (f_ack) state_next = tcprx_pkg::ST_CLOSED;
                end
                default: begin
                    state_next = state_cur;
                end
            endcase
        end
    end

    // reply and event outputs
    always_comb begin
        res                = '0;
        res.reply_kind     = tcprx_pkg::REPLY_NONE;
        res.new_state      = state_next;
        res.unacked_out    = is_seg ? seg.ack_num : unacked_cur;
        res.rcv_next_out   = is_seg ? seg.seq_end : rcv_next_cur;
        if (is_seg) begin
            case (state_cur)
                tcprx_pkg::ST_CLOSED: begin
                    res.reply_kind  = tcprx_pkg::REPLY_RST;
                    res.reply_count = 2'd1;
                end
                tcprx_pkg::ST_LISTEN: begin
                    res.reply_count = 2'd1;
                    if (f_syn) begin
                        res.spawn_child = 1'b1;
                        res.reply_kind  = tcprx_pkg::REPLY_SYNACK;
                    end else begin
                        res.reply_kind  = tcprx_pkg::REPLY_RST;
                    end
                end
                tcprx_pkg::ST_SYN_SENT: begin
                    res.reply_count = 2'd1;
                    if (f_syn || f_ack) begin
                        res.reply_kind   = tcprx_pkg::REPLY_ACK;
                        res.wake_connect = 1'b1;
                    end else begin
                        res.reply_kind   = tcprx_pkg::REPLY_RST;
                    end
                end
                tcprx_pkg::ST_SYN_RECV: begin
                    if (seg.seg_flags == tcprx_pkg::TCP_ACK && seg.ack_num == seg.send_next) begin
                        res.accept_ready = 1'b1;
                    end else begin
                        res.reply_kind   = tcprx_pkg::REPLY_RST;
                        res.reply_count  = 2'd1;
                    end
                end
                tcprx_pkg::ST_ESTABLISHED: begin
                    if (seg.seg_flags == tcprx_pkg::FLAGS_PSH_ACK) begin
                        res.deliver_valid = 1'b1;
                        res.deliver_len   = seg.payload_len;
                        res.reply_kind    = tcprx_pkg::REPLY_ACK;
                        res.reply_count   = 2'd1;
                    end else if (seg.seg_flags == tcprx_pkg::FLAGS_FIN_ACK) begin
                        res.reply_kind    = tcprx_pkg::REPLY_FINACK;
                        res.reply_count   = 2'd1;
                    end else if (seg.seg_flags == tcprx_pkg::TCP_FIN) begin
                        res.reply_kind    = tcprx_pkg::REPLY_ACK;
                        res.reply_count   = 2'd1;
                    end
                end
                tcprx_pkg::ST_FIN_WAIT_1: begin
                    // one ack per flag seen, fin and ack together give two
                    if (f_fin || f_ack) res.reply_kind = tcprx_pkg::REPLY_ACK;
                    res.reply_count    = {1'b0, f_fin} + {1'b0, f_ack};
                    res.start_timewait = f_fin;
                end
                tcprx_pkg::ST_FIN_WAIT_2: begin
                    if (f_fin || f_ack) begin
                        res.reply_kind     = tcprx_pkg::REPLY_ACK;
                        res.reply_count    = 2'd1;
                        res.start_timewait = 1'b1;
                    end
                end
                tcprx_pkg::ST_CLOSE_WAIT: begin
                    if (f_fin || f_ack) begin
                        res.reply_kind  = tcprx_pkg::REPLY_FINACK;
                        res.reply_count = 2'd1;
                    end
                end
                default: begin
                    res.reply_kind = tcprx_pkg::REPLY_NONE;
                end
            endcase
        end
    end

endmodule

>>> src/tcp_connection_receive_fsm.sv
// top level of the tcp connection receive state machine: stream ports,
// input register, connection state registers and result register
// depends on tcprx_pkg and tcprx_decode
//
// path: an accepted input word passes the input register, then the result register, onto m_tdata
// throughput: one word per cycle unless m_tready stalls the result register; the state update is a
// combinational decode between the input register and the result register
// reset: synchronous active-low aresetn empties both registers and sets the
// connection to CLOSED with zero sequence numbers

module tcp_connection_receive_fsm (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] seg_flags, [39:8] seq_end, [71:40] ack_num, [87:72] payload_len,
    // [119:88] send_next, [123:120] forced_state, [127:124] zero
    input  logic [tcprx_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] cmd
    input  logic                             s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] new_state, [6:4] reply_kind, [8:7] reply_count, [9] spawn_child,
    // [10] accept_ready, [11] wake_connect, [12] start_timewait,
    // [13] deliver_valid, [29:14] deliver_len, [61:30] unacked_out,
    // [93:62] rcv_next_out, [95:94] zero
    output logic [tcprx_pkg::M_DATA_W-1:0]   m_tdata
);

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    tcprx_pkg::seg_t   in_seg_reg;
    tcprx_pkg::seg_t   seg_unpacked;

    // connection state, updated when a word moves into the result register
    logic [3:0]        state_reg;
    logic [31:0]       unacked_reg;
    logic [31:0]       rcv_next_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    tcprx_pkg::result_t out_res_reg;
    tcprx_pkg::result_t dec_res;

    logic              advance;
    logic              s_accept;

    // the result register frees up when empty or being drained this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign seg_unpacked.cmd          = s_tuser;
    assign seg_unpacked.seg_flags    = s_tdata[7:0];
    assign seg_unpacked.seq_end      = s_tdata[39:8];
    assign seg_unpacked.ack_num      = s_tdata[71:40];
    assign seg_unpacked.payload_len  = s_tdata[87:72];
    assign seg_unpacked.send_next    = s_tdata[119:88];
    assign seg_unpacked.forced_state = s_tdata[123:120];

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    tcprx_decode u_decode (
        .seg          (in_seg_reg),
        .state_cur    (state_reg),
        .unacked_cur  (unacked_reg),
        .rcv_next_cur (rcv_next_reg),
        .res          (dec_res)
    );

    // control and connection state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= tcprx_pkg::ST_CLOSED;
            unacked_reg   <= 32'd0;
            rcv_next_reg  <= 32'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg    <= dec_res.new_state;
                unacked_reg  <= dec_res.unacked_out;
                rcv_next_reg <= dec_res.rcv_next_out;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_seg_reg <= seg_unpacked;
        end
        if (advance) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.rcv_next_out,
                       out_res_reg.unacked_out,
                       out_res_reg.deliver_len,
                       out_res_reg.deliver_valid,
                       out_res_reg.start_timewait,
                       out_res_reg.wake_connect,
                       out_res_reg.accept_ready,
                       out_res_reg.spawn_child,
                       out_res_reg.reply_count,
                       out_res_reg.reply_kind,
                       out_res_reg.new_state};

    // a reply kind always comes with copies, and no kind means no copies
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[6:4] == tcprx_pkg::REPLY_NONE) == (m_tdata[8:7] == 2'd0)))
        else $error("reply kind and copy count disagree");

    // two copies only happen as acks out of fin_wait_1 into time_wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8:7] == 2'd2) |->
            (m_tdata[6:4] == tcprx_pkg::REPLY_ACK && m_tdata[3:0] == tcprx_pkg::ST_TIME_WAIT))
        else $error("double reply outside fin_wait_1 close");

    // time-wait timer starts only on entry to time_wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12]) |-> (m_tdata[3:0] == tcprx_pkg::ST_TIME_WAIT))
        else $error("time-wait start without time_wait state");

    // the connection state register follows the result just produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (state_reg == out_res_reg.new_state && out_valid_reg))
        else $error("connection state out of step with result");

    // delivery length is zero unless delivering
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[13]) |-> (m_tdata[29:14] == 16'd0))
        else $error("deliver length without deliver");

endmodule
